### rtl/sir_pkg.sv
// Shared types and codes for the sync-point interrupt router.
package sir_pkg;

    typedef enum logic [2:0] {
        MODE_ENABLE_ROUTE = 3'd0,
        MODE_WRITE_HALF   = 3'd1,
        MODE_CLEAR_ROUTE  = 3'd2,
        MODE_RAISE_POINT  = 3'd3,
        MODE_CLEAR_STATUS = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]  mode;
        logic        processor;
        logic [31:0] mask_value;
        logic        half;
        logic [4:0]  point_index;
        logic [31:0] crossed;
    } t_in_word;

    typedef struct packed {
        logic        cpu_pending;
        logic        cop_pending;
        logic        cpu_changed;
        logic        cop_changed;
        logic [31:0] cpu_status;
        logic [31:0] cop_status;
        logic [63:0] route_mask;
    } t_out_word;

endpackage

### rtl/syncpoint_interrupt_router.sv
// Top level of the sync-point interrupt router: input register, update logic, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) carries one operation word:
//   enable routing, write a route half, clear routes, raise a point or clear status.
//   Output channel (o_out_valid / i_out_ready / o_out_word) returns one result word
//   per operation: both pending lines, their change flags, both status words and
//   the 64-bit routing mask as they stand after the operation.
//   An accepted word sits in the input register until the result register is free;
//   its result is then loaded into the result register, which sets o_out_valid.
//   Throughput is one word per cycle while the receiver is not stalling; the update
//   of the routing, status and pending registers is a single pass of bitwise logic
//   over all points.
//   While the receiver stalls, the result register holds; one more word waits in the
//   input register, after which o_in_ready drops until the result is taken.
//   Synchronous reset clears routing, status, pending lines and both valid flags.
module syncpoint_interrupt_router #(
    parameter int POINTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sir_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sir_pkg::t_out_word o_out_word
);

    localparam logic [31:0] PMASK = 32'((64'd1 << POINTS) - 64'd1);

    logic               r_in_valid;
    sir_pkg::t_in_word  r_in;
    logic               r_out_valid;
    sir_pkg::t_out_word r_out;
    logic [63:0]        r_route;
    logic [31:0]        r_cpu_st;
    logic [31:0]        r_cop_st;
    logic [1:0]         r_pend;

    logic [63:0]        n_route;
    logic [31:0]        n_cpu_st;
    logic [31:0]        n_cop_st;
    logic [1:0]         n_pend;
    sir_pkg::t_out_word n_out;

    logic               advance;
    logic [31:0]        pm;
    logic [31:0]        hit;
    logic [31:0]        hit_cpu;
    logic [31:0]        hit_cop;
    logic [31:0]        routed;
    logic [31:0]        clr;

    function automatic logic [31:0] routed_of(input logic [63:0] route, input logic p);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < POINTS) begin
                r[i] = route[2*i + int'(p)];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] spread(input logic [31:0] m, input logic p);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            r[2*i + int'(p)] = m[i];
        end
        return r;
    endfunction

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign pm         = r_in.mask_value & PMASK;

    always_comb begin
        n_route  = r_route;
        n_cpu_st = r_cpu_st;
        n_cop_st = r_cop_st;
        n_pend   = r_pend;
        hit      = '0;
        hit_cpu  = '0;
        hit_cop  = '0;
        routed   = routed_of(r_route, r_in.processor);
        clr      = pm & ~(routed & r_in.crossed);
        unique case (sir_pkg::t_mode'(r_in.mode))
            sir_pkg::MODE_ENABLE_ROUTE: begin
                n_route = r_route | spread(pm, r_in.processor);
                hit     = pm & r_in.crossed;
                hit_cpu = hit & routed_of(n_route, 1'b0);
                hit_cop = hit & routed_of(n_route, 1'b1);
            end
            sir_pkg::MODE_WRITE_HALF: begin
                if (r_in.half) begin
                    n_route[63:32] = r_in.mask_value;
                end else begin
                    n_route[31:0] = r_in.mask_value;
                end
            end
            sir_pkg::MODE_CLEAR_ROUTE: begin
                n_route = r_route & ~(spread(pm, 1'b0) | spread(pm, 1'b1));
            end
            sir_pkg::MODE_RAISE_POINT: begin
                if (int'(r_in.point_index) < POINTS) begin
                    hit = 32'd1 << r_in.point_index;
                end
                hit_cpu = hit & routed_of(r_route, 1'b0);
                hit_cop = hit & routed_of(r_route, 1'b1);
            end
            sir_pkg::MODE_CLEAR_STATUS: begin
                if (r_in.processor) begin
                    n_cop_st  = r_cop_st & ~clr;
                    n_pend[1] = |(n_cop_st & routed);
                end else begin
                    n_cpu_st  = r_cpu_st & ~clr;
                    n_pend[0] = |(n_cpu_st & routed);
                end
            end
            default: begin
            end
        endcase
        n_cpu_st = n_cpu_st | hit_cpu;
        n_cop_st = n_cop_st | hit_cop;
        if (|hit_cpu) begin
            n_pend[0] = 1'b1;
        end
        if (|hit_cop) begin
            n_pend[1] = 1'b1;
        end

        n_out.cpu_pending = n_pend[0];
        n_out.cop_pending = n_pend[1];
        n_out.cpu_changed = n_pend[0] ^ r_pend[0];
        n_out.cop_changed = n_pend[1] ^ r_pend[1];
        n_out.cpu_status  = n_cpu_st;
        n_out.cop_status  = n_cop_st;
        n_out.route_mask  = n_route;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_route     <= '0;
            r_cpu_st    <= '0;
            r_cop_st    <= '0;
            r_pend      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_route     <= n_route;
                r_cpu_st    <= n_cpu_st;
                r_cop_st    <= n_cop_st;
                r_pend      <= n_pend;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/sir_checker.sv
// Port-level checks for the sync-point interrupt router, bound to the top level.
module sir_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input sir_pkg::t_out_word i_out_word
);

    logic [1:0] r_prev_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pend <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_prev_pend <= {i_out_word.cop_pending, i_out_word.cpu_pending};
        end
    end

    a_cpu_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.cpu_changed == (i_out_word.cpu_pending ^ r_prev_pend[0]))
        else $error("cpu changed flag disagrees with previous word");

    a_cop_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.cop_changed == (i_out_word.cop_pending ^ r_prev_pend[1]))
        else $error("cop changed flag disagrees with previous word");

    a_pend_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.cpu_pending || i_out_word.cop_pending) |->
            (!i_out_word.cpu_pending || i_out_word.cpu_status != '0) &&
            (!i_out_word.cop_pending || i_out_word.cop_status != '0))
        else $error("pending line high with empty status word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("stalled result word changed");

endmodule

bind syncpoint_interrupt_router sir_checker u_sir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_word  (o_out_word)
);
